// ===== sv/bfr_pkg.sv =====
package bfr_pkg;

  // Default number of slots in the entry store.
  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LIMIT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Command codes.
  localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_PUSH = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PUSH_ONLY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

endpackage

// ===== sv/bfr_ram.sv =====
module bfr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same address in one cycle return the old word.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== sv/bounded_fifo_with_remove.sv =====
// Bounded FIFO of 64-bit values with delete-by-value.
//
// Commands enter on in_opcode/in_value and are transferred at a rising edge where start
// is high and busy is low. Every command produces exactly one result, shown on out_status,
// out_popped_value and out_entry_count for a single cycle while out_valid is high. The
// receiver cannot stall the block, so each result must be taken in the cycle it appears.
// The entry limit is written on the cfg_ channel (cfg_ready is always high) and should
// only be changed while no command is in progress.
//
// Push, pop, pop-push, clear and unused codes never raise busy: the result appears in
// the cycle after the transfer and a new command may be transferred in that same cycle.
// Remove walks the held entries through the single read port of the entry memory, one
// entry per cycle, then shifts the younger entries down one slot per cycle through the
// same port. It holds busy until it finishes; the result appears as busy drops. Remove
// on an empty queue never raises busy.
//
// Reset empties the queue, sets the entry limit to 64 and clears any pending result.
// Memory contents are not cleared; only values from written slots ever reach the outputs.
module bounded_fifo_with_remove #(
  parameter int unsigned DEPTH = bfr_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Command channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [bfr_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [bfr_pkg::VALUE_W-1:0]    in_value,
  // Result channel.
  output logic                           out_valid,
  output logic [bfr_pkg::STATUS_W-1:0]   out_status,
  output logic [bfr_pkg::VALUE_W-1:0]    out_popped_value,
  output logic [bfr_pkg::COUNT_W-1:0]    out_entry_count,
  // Configuration channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfr_pkg::LIMIT_W-1:0]    cfg_entry_limit
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Width wide enough for both the count and the 7-bit limit.
  localparam int unsigned LW = (CW > bfr_pkg::LIMIT_W) ? CW : bfr_pkg::LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } state_t;

  // Maps a position counted from the oldest entry to a physical slot. The sum stays
  // below twice DEPTH, so one compare and subtract wraps it.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 oldest_r, oldest_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [bfr_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [bfr_pkg::VALUE_W-1:0]   key_r, key_nxt;
  logic [CW-1:0]                 pos_r, pos_nxt;
  logic                          cmp_valid_r, cmp_valid_nxt;
  logic [CW-1:0]                 cmp_pos_r, cmp_pos_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bfr_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                          pop_sel_r, pop_sel_nxt;

  logic                          accept;
  logic [LW-1:0]                 lim_eff;
  logic                          at_limit;
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [bfr_pkg::VALUE_W-1:0]   ram_wdata;
  logic [IW-1:0]                 ram_raddr;
  logic [bfr_pkg::VALUE_W-1:0]   ram_rdata;
  logic [LW-1:0]                 count_ext;
  logic                          last_cmp;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // A limit above the store size saturates to the store size.
  assign lim_eff  = (LW'(limit_r) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit_r);
  assign at_limit = (LW'(count_r) >= lim_eff);

  // Set when the data in ram_rdata belongs to the last position held in the queue.
  assign last_cmp = (cmp_pos_r == count_r - CW'(1));

  // While idle the read port always looks at the oldest slot, so a pop transferred at an
  // edge finds its value on the RAM output in the following cycle.
  assign ram_raddr = (state_r == S_IDLE) ? oldest_r : slot_of(oldest_r, pos_r);

  bfr_ram #(
    .WIDTH (bfr_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    cmp_valid_nxt = 1'b0;
    cmp_pos_nxt   = cmp_pos_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    pop_sel_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_of(oldest_r, count_r);
    ram_wdata     = in_value;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_entry_limit;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = bfr_pkg::ST_DONE;
          case (in_opcode)
            bfr_pkg::OP_PUSH: begin
              if (at_limit) begin
                status_nxt = bfr_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            bfr_pkg::OP_POP: begin
              if (count_r == '0) begin
                status_nxt = bfr_pkg::ST_EMPTY;
              end else begin
                pop_sel_nxt = 1'b1;
                oldest_nxt  = (oldest_r == IW'(DEPTH - 1)) ? '0 : oldest_r + IW'(1);
                count_nxt   = count_r - CW'(1);
              end
            end
            bfr_pkg::OP_POP_PUSH: begin
              // The append slot is oldest + count; on a full store that is the popped
              // slot itself, which the read-first RAM returns before overwriting.
              ram_we = 1'b1;
              if (count_r == '0) begin
                status_nxt = bfr_pkg::ST_PUSH_ONLY;
                count_nxt  = CW'(1);
              end else begin
                pop_sel_nxt = 1'b1;
                oldest_nxt  = (oldest_r == IW'(DEPTH - 1)) ? '0 : oldest_r + IW'(1);
              end
            end
            bfr_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = bfr_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                key_nxt       = in_value;
                pos_nxt       = '0;
                state_nxt     = S_SEARCH;
              end
            end
            bfr_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              oldest_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        // One read issued per cycle; each compare runs in the cycle after its read.
        if (pos_r < count_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_pos_nxt   = pos_r;
          pos_nxt       = pos_r + CW'(1);
        end
        if (cmp_valid_r) begin
          if (ram_rdata == key_r) begin
            cmp_valid_nxt = 1'b0;
            if (last_cmp) begin
              // The youngest entry matched: nothing to shift.
              count_nxt     = count_r - CW'(1);
              status_nxt    = bfr_pkg::ST_REMOVED;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              pos_nxt   = cmp_pos_r + CW'(1);
              state_nxt = S_SHIFT;
            end
          end else if (last_cmp) begin
            cmp_valid_nxt = 1'b0;
            status_nxt    = bfr_pkg::ST_NOT_FOUND;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // Each entry read here is written one position closer to the oldest entry.
        // Reads run ahead of writes, so no read sees a slot still waiting to be written.
        if (pos_r < count_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_pos_nxt   = pos_r;
          pos_nxt       = pos_r + CW'(1);
        end
        if (cmp_valid_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(oldest_r, cmp_pos_r - CW'(1));
          ram_wdata = ram_rdata;
          if (last_cmp) begin
            cmp_valid_nxt = 1'b0;
            count_nxt     = count_r - CW'(1);
            status_nxt    = bfr_pkg::ST_REMOVED;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      limit_r     <= bfr_pkg::LIMIT_RESET;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pop_sel_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pop_sel_r   <= pop_sel_nxt;
    end
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    cmp_pos_r <= cmp_pos_nxt;
    status_r  <= status_nxt;
  end

  // The count is reported masked to the width of the result field.
  assign count_ext        = LW'(count_r);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_entry_count  = count_ext[bfr_pkg::COUNT_W-1:0];
  // A popped value arrives straight from the RAM's output register.
  assign out_popped_value = pop_sel_r ? ram_rdata : '0;

endmodule

// ===== sv/bfr_checker.sv =====
module bfr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [bfr_pkg::STATUS_W-1:0] out_status,
  input logic [bfr_pkg::VALUE_W-1:0]  out_popped_value,
  input logic [bfr_pkg::COUNT_W-1:0]  out_entry_count
);

  // Every transfer either produces its result next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("transfer neither answered nor started a long command");

  // A long command ends by delivering its result.
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // No result appears without a command behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("result without a command");

  // An empty report always comes with a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bfr_pkg::ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with a nonzero count");

  // Only a successful pop or pop-push carries a nonzero popped value.
  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_popped_value != '0) |-> (out_status == bfr_pkg::ST_DONE))
    else $error("popped value on a result that popped nothing");

endmodule

bind bounded_fifo_with_remove bfr_checker u_bfr_checker (.*);
